// ===== hdl/csse_pkg.sv =====
// ----------------------------------------------------------------------------
// csse_pkg: shared types and constants of the cubic shading surface evaluator
// Fixed-point widths, coefficient set, stage enables and register indexes.
// ----------------------------------------------------------------------------
package csse_pkg;

  // coordinate and fixed-point format
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int COEF_W     = 48;
  localparam int NUM_COEFS  = 7;
  localparam int IDX_W      = 3;

  // square and widest power of a coordinate (cube)
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int POW_W      = 3 * COORD_BITS;

  // coefficient split for the partial products
  localparam int COEF_LO_W  = COEF_W / 2;
  localparam int COEF_HI_W  = COEF_W - COEF_LO_W;
  localparam int PLO_W      = COEF_LO_W + POW_W;
  localparam int PHI_W      = COEF_HI_W + POW_W + 1;
  localparam int PROD_W     = COEF_W + POW_W + 1;

  // aligned term and running sum
  localparam int TERM_W     = COEF_W + 1;
  localparam int SUM_W      = TERM_W + 3;

  // output byte
  localparam int LUM_W      = 8;
  localparam logic [LUM_W-1:0] LUM_MAX = {LUM_W{1'b1}};
  localparam logic signed [SUM_W-1:0] SUM_TOP =
    SUM_W'({{(SUM_W-LUM_W){1'b0}}, LUM_MAX}) <<< FRAC_BITS;

  // pipeline depth, input register to output register
  localparam int NUM_STAGES = 8;

  // register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_COEF_CONST = 3'd0,
    REG_COEF_Y1    = 3'd1,
    REG_COEF_Y2    = 3'd2,
    REG_COEF_Y3    = 3'd3,
    REG_COEF_X1    = 3'd4,
    REG_COEF_X2    = 3'd5,
    REG_COEF_X3    = 3'd6
  } reg_idx_t;

  // degree of a term, sets the alignment shift
  typedef enum logic [1:0] {
    DEG_1 = 2'd1,
    DEG_2 = 2'd2,
    DEG_3 = 2'd3
  } deg_t;

  // full coefficient set
  typedef struct packed {
    logic signed [COEF_W-1:0] c0;
    logic signed [COEF_W-1:0] y1;
    logic signed [COEF_W-1:0] y2;
    logic signed [COEF_W-1:0] y3;
    logic signed [COEF_W-1:0] x1;
    logic signed [COEF_W-1:0] x2;
    logic signed [COEF_W-1:0] x3;
  } coef_t;

  // per-stage load enables, last stage in the top bit
  typedef struct packed {
    logic s8;
    logic s7;
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } pipe_en_t;

endpackage

// ===== hdl/csse_coef_regs.sv =====
// ----------------------------------------------------------------------------
// csse_coef_regs: coefficient register file
// Seven signed coefficients written through a plain index/data port.
// ----------------------------------------------------------------------------
module csse_coef_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [csse_pkg::IDX_W-1:0]      cfg_addr,
  input  logic [csse_pkg::COEF_W-1:0]     cfg_wdata,
  output csse_pkg::coef_t                 coef
);
  import csse_pkg::*;

  // write the addressed coefficient, ignore indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg_wen) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_COEF_CONST: coef.c0 <= cfg_wdata;
        REG_COEF_Y1:    coef.y1 <= cfg_wdata;
        REG_COEF_Y2:    coef.y2 <= cfg_wdata;
        REG_COEF_Y3:    coef.y3 <= cfg_wdata;
        REG_COEF_X1:    coef.x1 <= cfg_wdata;
        REG_COEF_X2:    coef.x2 <= cfg_wdata;
        REG_COEF_X3:    coef.x3 <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/csse_pow.sv =====
// ----------------------------------------------------------------------------
// csse_pow: coordinate powers
// Squares in stage 1, cubes in stage 2, all widened to the cube width.
// ----------------------------------------------------------------------------
module csse_pow (
  input  logic                             clk,
  input  csse_pkg::pipe_en_t               en,
  input  logic [csse_pkg::COORD_BITS-1:0]  col,
  input  logic [csse_pkg::COORD_BITS-1:0]  row,
  output logic [csse_pkg::POW_W-1:0]       px1,
  output logic [csse_pkg::POW_W-1:0]       px2,
  output logic [csse_pkg::POW_W-1:0]       px3,
  output logic [csse_pkg::POW_W-1:0]       py1,
  output logic [csse_pkg::POW_W-1:0]       py2,
  output logic [csse_pkg::POW_W-1:0]       py3
);
  import csse_pkg::*;

  logic [COORD_BITS-1:0] x_s1, y_s1, x_s2, y_s2;
  logic [SQ_W-1:0]       xsq_next, ysq_next;
  logic [SQ_W-1:0]       xsq_s1, ysq_s1, xsq_s2, ysq_s2;
  logic [POW_W-1:0]      xcb_next, ycb_next;
  logic [POW_W-1:0]      xcb_s2, ycb_s2;

  assign xsq_next = col * col;
  assign ysq_next = row * row;
  assign xcb_next = xsq_s1 * x_s1;
  assign ycb_next = ysq_s1 * y_s1;

  // stage 1: hold coordinates and squares
  always_ff @(posedge clk) begin
    if (en.s1) begin
      x_s1   <= col;
      y_s1   <= row;
      xsq_s1 <= xsq_next;
      ysq_s1 <= ysq_next;
    end
  end

  // stage 2: add the cubes
  always_ff @(posedge clk) begin
    if (en.s2) begin
      x_s2   <= x_s1;
      y_s2   <= y_s1;
      xsq_s2 <= xsq_s1;
      ysq_s2 <= ysq_s1;
      xcb_s2 <= xcb_next;
      ycb_s2 <= ycb_next;
    end
  end

  assign px1 = {{(POW_W-COORD_BITS){1'b0}}, x_s2};
  assign py1 = {{(POW_W-COORD_BITS){1'b0}}, y_s2};
  assign px2 = {{(POW_W-SQ_W){1'b0}}, xsq_s2};
  assign py2 = {{(POW_W-SQ_W){1'b0}}, ysq_s2};
  assign px3 = xcb_s2;
  assign py3 = ycb_s2;

endmodule

// ===== hdl/csse_term.sv =====
// ----------------------------------------------------------------------------
// csse_term: one polynomial term
// Coefficient times coordinate power as two partial products in stage 3,
// joined and aligned to the output fraction (floor) in stage 4.
// ----------------------------------------------------------------------------
module csse_term (
  input  logic                                clk,
  input  csse_pkg::pipe_en_t                  en,
  input  csse_pkg::deg_t                      deg,
  input  logic signed [csse_pkg::COEF_W-1:0]  coef,
  input  logic [csse_pkg::POW_W-1:0]          pw,
  output logic signed [csse_pkg::TERM_W-1:0]  term
);
  import csse_pkg::*;

  logic [PLO_W-1:0]         pl_next, pl;
  logic signed [PHI_W-1:0]  ph_next, ph;
  logic signed [PROD_W-1:0] prod, shifted;
  logic signed [TERM_W-1:0] term_next;

  // split the coefficient: unsigned low half, signed high half
  assign pl_next = coef[COEF_LO_W-1:0] * pw;
  assign ph_next = $signed(coef[COEF_W-1:COEF_LO_W]) * $signed({1'b0, pw});

  // stage 3: hold the partial products
  always_ff @(posedge clk) begin
    if (en.s3) begin
      pl <= pl_next;
      ph <= ph_next;
    end
  end

  // join into the exact product
  assign prod = $signed({ph, {COEF_LO_W{1'b0}}})
              + $signed({{(PROD_W-PLO_W){1'b0}}, pl});

  // align by the degree's fraction, rounding toward minus infinity
  always_comb begin
    unique case (deg)
      DEG_1:   shifted = prod >>> COORD_BITS;
      DEG_2:   shifted = prod >>> (2 * COORD_BITS);
      DEG_3:   shifted = prod >>> (3 * COORD_BITS);
      default: shifted = '0;
    endcase
    term_next = shifted[TERM_W-1:0];
  end

  // stage 4: hold the aligned term
  always_ff @(posedge clk) begin
    if (en.s4) begin
      term <= term_next;
    end
  end

endmodule

// ===== hdl/csse_sum.sv =====
// ----------------------------------------------------------------------------
// csse_sum: term summation and clamp
// Registered adder tree over stages 5 to 7, clamp to a byte in stage 8.
// ----------------------------------------------------------------------------
module csse_sum (
  input  logic                                clk,
  input  csse_pkg::pipe_en_t                  en,
  input  logic signed [csse_pkg::COEF_W-1:0]  c0,
  input  logic signed [csse_pkg::TERM_W-1:0]  ty1,
  input  logic signed [csse_pkg::TERM_W-1:0]  ty2,
  input  logic signed [csse_pkg::TERM_W-1:0]  ty3,
  input  logic signed [csse_pkg::TERM_W-1:0]  tx1,
  input  logic signed [csse_pkg::TERM_W-1:0]  tx2,
  input  logic signed [csse_pkg::TERM_W-1:0]  tx3,
  output logic [csse_pkg::LUM_W-1:0]          lum,
  output logic                                clamped
);
  import csse_pkg::*;

  logic signed [SUM_W-1:0] a0, a1, a2, a3;
  logic signed [SUM_W-1:0] b0, b1;
  logic signed [SUM_W-1:0] total;
  logic [LUM_W-1:0]        lum_next;
  logic                    clamped_next;

  // stage 5: pair up the seven terms
  always_ff @(posedge clk) begin
    if (en.s5) begin
      a0 <= SUM_W'(c0) + SUM_W'(ty1);
      a1 <= SUM_W'(ty2) + SUM_W'(ty3);
      a2 <= SUM_W'(tx1) + SUM_W'(tx2);
      a3 <= SUM_W'(tx3);
    end
  end

  // stage 6: second level
  always_ff @(posedge clk) begin
    if (en.s6) begin
      b0 <= a0 + a1;
      b1 <= a2 + a3;
    end
  end

  // stage 7: full sum
  always_ff @(posedge clk) begin
    if (en.s7) begin
      total <= b0 + b1;
    end
  end

  // clamp: negative to zero, anything above 255.0 to the top
  always_comb begin
    priority if (total[SUM_W-1]) begin
      lum_next     = '0;
      clamped_next = 1'b1;
    end else if (total > SUM_TOP) begin
      lum_next     = LUM_MAX;
      clamped_next = 1'b1;
    end else begin
      lum_next     = total[FRAC_BITS+LUM_W-1:FRAC_BITS];
      clamped_next = 1'b0;
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (en.s8) begin
      lum     <= lum_next;
      clamped <= clamped_next;
    end
  end

endmodule

// ===== hdl/cubic_shading_surface_eval_core.sv =====
// ----------------------------------------------------------------------------
// cubic_shading_surface_eval_core: separable cubic surface evaluator
// Predicts background luminance from a pixel coordinate and clamps it.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+--------------------------------
//   in       | in_valid / in_stall   | col, row (12 b each)
//   out      | out_valid / out_stall | lum (8 b), clamped (1 b)
//   cfg      | cfg_wen               | cfg_addr (3 b), cfg_wdata (48 b)
//
// One item per clock while out_stall is low; each item passes through the eight
// register stages (powers, split multiply, align, adder tree, clamp) and
// out_valid rises when it reaches the last of them.
// Reset clears the stage valid bits and all coefficients to zero.
// Each stage loads when empty or when the one after it moves, so bubbles
// close up under out_stall; in_stall rises only with every stage full.
// ----------------------------------------------------------------------------
module cubic_shading_surface_eval_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [csse_pkg::COORD_BITS-1:0]  col,
  input  logic [csse_pkg::COORD_BITS-1:0]  row,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [csse_pkg::LUM_W-1:0]       lum,
  output logic                             clamped,
  input  logic                             cfg_wen,
  input  logic [csse_pkg::IDX_W-1:0]       cfg_addr,
  input  logic [csse_pkg::COEF_W-1:0]      cfg_wdata
);
  import csse_pkg::*;

  logic [NUM_STAGES:1]     vld;
  logic [NUM_STAGES:1]     load;
  pipe_en_t                en;
  coef_t                   coef;
  logic [POW_W-1:0]        px1, px2, px3, py1, py2, py3;
  logic signed [TERM_W-1:0] ty1, ty2, ty3, tx1, tx2, tx3;

  // load chain: a stage moves when empty or its successor moves
  always_comb begin
    load[NUM_STAGES] = !vld[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      load[k] = !vld[k] || load[k+1];
    end
  end

  assign en        = pipe_en_t'(load);
  assign in_stall  = !load[1];
  assign out_valid = vld[NUM_STAGES];

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~load) | ({vld[NUM_STAGES-1:1], in_valid} & load);
    end
  end

  csse_coef_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  csse_pow u_pow (
    .clk (clk),
    .en  (en),
    .col (col),
    .row (row),
    .px1 (px1),
    .px2 (px2),
    .px3 (px3),
    .py1 (py1),
    .py2 (py2),
    .py3 (py3)
  );

  csse_term u_ty1 (.clk(clk), .en(en), .deg(DEG_1), .coef(coef.y1), .pw(py1), .term(ty1));
  csse_term u_ty2 (.clk(clk), .en(en), .deg(DEG_2), .coef(coef.y2), .pw(py2), .term(ty2));
  csse_term u_ty3 (.clk(clk), .en(en), .deg(DEG_3), .coef(coef.y3), .pw(py3), .term(ty3));
  csse_term u_tx1 (.clk(clk), .en(en), .deg(DEG_1), .coef(coef.x1), .pw(px1), .term(tx1));
  csse_term u_tx2 (.clk(clk), .en(en), .deg(DEG_2), .coef(coef.x2), .pw(px2), .term(tx2));
  csse_term u_tx3 (.clk(clk), .en(en), .deg(DEG_3), .coef(coef.x3), .pw(px3), .term(tx3));

  csse_sum u_sum (
    .clk     (clk),
    .en      (en),
    .c0      (coef.c0),
    .ty1     (ty1),
    .ty2     (ty2),
    .ty3     (ty3),
    .tx1     (tx1),
    .tx2     (tx2),
    .tx3     (tx3),
    .lum     (lum),
    .clamped (clamped)
  );

  // input stalls only when the output is held and every stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && (&vld)))
    else $error("input stalled with room in the pipeline");

  // a free output never stalls the input
  a_free_out: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output was free");

  // an accepted item occupies the first stage on the next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted item missing from first stage");

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

// ===== sim/tb_cubic_shading_surface_eval_core.sv =====
// ----------------------------------------------------------------------------
// tb_cubic_shading_surface_eval_core: self-checking bench of the surface core
// Loads coefficient sets through the write port, drives pixel coordinates and
// compares every luminance item with a bit-exact fixed-point surface predictor.
// ----------------------------------------------------------------------------
module tb_cubic_shading_surface_eval_core;
  timeunit 1ns;
  timeprecision 1ps;

  import csse_pkg::*;

  localparam int ACC_W       = 128;
  localparam int HOLD_CYCLES = 40;
  localparam int RAND_SETS   = 8;
  localparam int SET_ITEMS   = 250;

  // address past the last coefficient, writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  localparam logic signed [ACC_W-1:0] LUM_TOP = 128'sd255 <<< FRAC_BITS;
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic [LUM_W-1:0] lum;
    logic             clamped;
  } lum_item_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  logic                  out_valid;
  logic                  out_stall;
  logic [LUM_W-1:0]      lum;
  logic                  clamped;
  logic                  cfg_wen;
  logic [IDX_W-1:0]      cfg_addr;
  logic [COEF_W-1:0]     cfg_wdata;

  // testbench copy of the coefficient registers
  coef_t       coef_shadow;
  lum_item_t   lum_expected_q[$];

  int  mismatch_count   = 0;
  int  coords_sent      = 0;
  int  lum_checked      = 0;
  int  clamp_seen       = 0;
  int  coef_sets_loaded = 0;
  int  in_stall_cycles  = 0;
  int  hold_seq         = 0;
  bit  tx_idle_on       = 1'b0;
  bit  rx_idle_on;

  cubic_shading_surface_eval_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .col       (col),
    .row       (row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lum       (lum),
    .clamped   (clamped),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one degree-d term: exact product, then floor to FRAC_BITS fraction bits
  function automatic logic signed [ACC_W-1:0] aligned_term(
    input logic signed [COEF_W-1:0] c,
    input logic [POW_W-1:0]         p,
    input int                       deg
  );
    logic signed [ACC_W-1:0] cw;
    logic signed [ACC_W-1:0] pw;
    cw = c;
    pw = {{(ACC_W-POW_W){1'b0}}, p};
    return (cw * pw) >>> (COORD_BITS * deg);
  endfunction

  // evaluate the surface at (x, y) and clamp to a byte
  function automatic lum_item_t predict_luminance(
    input logic [COORD_BITS-1:0] x,
    input logic [COORD_BITS-1:0] y
  );
    logic [POW_W-1:0]        x1, x2, x3, y1, y2, y3;
    logic signed [ACC_W-1:0] acc;
    lum_item_t               r;
    x1 = POW_W'(x);
    x2 = x1 * x1;
    x3 = x2 * x1;
    y1 = POW_W'(y);
    y2 = y1 * y1;
    y3 = y2 * y1;
    acc = aligned_term(coef_shadow.c0, POW_W'(1), 0)
        + aligned_term(coef_shadow.y1, y1, 1)
        + aligned_term(coef_shadow.y2, y2, 2)
        + aligned_term(coef_shadow.y3, y3, 3)
        + aligned_term(coef_shadow.x1, x1, 1)
        + aligned_term(coef_shadow.x2, x2, 2)
        + aligned_term(coef_shadow.x3, x3, 3);
    if (acc < 0) begin
      r.lum     = '0;
      r.clamped = 1'b1;
    end else if (acc > LUM_TOP) begin
      r.lum     = LUM_MAX;
      r.clamped = 1'b1;
    end else begin
      r.lum     = acc[FRAC_BITS +: LUM_W];
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  // random signed value spanning the given number of bits
  function automatic logic signed [COEF_W-1:0] rand_coef(input int span);
    logic signed [63:0] raw;
    raw = $signed({$urandom, $urandom});
    raw = raw >>> (64 - span);
    return raw[COEF_W-1:0];
  endfunction

  // plausible shading surface: offset in range, each term worth about +-128
  function automatic coef_t rand_surface();
    coef_t s;
    s.c0 = COEF_W'($urandom_range(0, 255 << FRAC_BITS));
    s.y1 = rand_coef(24);
    s.y2 = rand_coef(24);
    s.y3 = rand_coef(24);
    s.x1 = rand_coef(24);
    s.x2 = rand_coef(24);
    s.x3 = rand_coef(24);
    return s;
  endfunction

  function automatic coef_t rand_full_range();
    coef_t s;
    s.c0 = rand_coef(COEF_W);
    s.y1 = rand_coef(COEF_W);
    s.y2 = rand_coef(COEF_W);
    s.y3 = rand_coef(COEF_W);
    s.x1 = rand_coef(COEF_W);
    s.x2 = rand_coef(COEF_W);
    s.x3 = rand_coef(COEF_W);
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(0, 1) ? '1 : '0;
    return COORD_BITS'($urandom);
  endfunction

  function automatic int tx_gap();
    return tx_idle_on ? $urandom_range(0, 3) : 0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_lum(input logic [LUM_W-1:0] got_lum, input logic got_clamped);
    lum_item_t want;
    if (lum_expected_q.size() == 0) begin
      report_mismatch("unexpected luminance item", got_lum, -1);
    end else begin
      want = lum_expected_q.pop_front();
      if (got_lum !== want.lum)
        report_mismatch("lum", got_lum, want.lum);
      if (got_clamped !== want.clamped)
        report_mismatch("clamped", got_clamped, want.clamped);
      lum_checked++;
      if (want.clamped)
        clamp_seen++;
    end
  endtask

  // drive one register write; the caller lowers the write enable
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // load all seven coefficients, then a stray write that must be dropped
  task automatic load_coefs(input coef_t s);
    write_reg(REG_COEF_CONST, s.c0);
    write_reg(REG_COEF_Y1,    s.y1);
    write_reg(REG_COEF_Y2,    s.y2);
    write_reg(REG_COEF_Y3,    s.y3);
    write_reg(REG_COEF_X1,    s.x1);
    write_reg(REG_COEF_X2,    s.x2);
    write_reg(REG_COEF_X3,    s.x3);
    write_reg(REG_UNUSED,     {$urandom, $urandom});
    cfg_wen     <= 1'b0;
    coef_shadow  = s;
    coef_sets_loaded++;
  endtask

  // offer one coordinate and hold it until the core takes it
  task automatic send_coord(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                            input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    col      <= x;
    row      <= y;
    do @(posedge clk); while (in_stall);
    lum_expected_q = {lum_expected_q, predict_luminance(x, y)};
    coords_sent++;
  endtask

  // drop valid and wait until every expected item has come back
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (lum_expected_q.size() != 0) @(posedge clk);
  endtask

  // receiver: check each item, then draw a stall or serve a long hold-off
  int rx_gap_left = 0;
  int hold_left   = 0;
  int hold_seen   = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      rx_gap_left  = 0;
      hold_left    = 0;
    end else begin
      if (in_valid && in_stall)
        in_stall_cycles++;
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (out_valid && !out_stall) begin
        check_lum(lum, clamped);
        rx_gap_left = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // coefficients are zero after reset, so every pixel reads zero unclamped
  task automatic test_reset_state();
    coef_shadow = '0;
    send_coord('0, '0, 0);
    send_coord('1, '1, 1);
    settle_pipeline();
  endtask

  // sums sitting on either side of the clamp limits, and floor rounding
  task automatic test_clamp_edges();
    coef_t s;
    s = '0;
    s.c0 = COEF_W'(255) <<< FRAC_BITS;          // exactly 255
    load_coefs(s);
    send_coord(12'd7, 12'd9, 0);
    settle_pipeline();
    s.c0 = (COEF_W'(255) <<< FRAC_BITS) + 48'sh8000;  // 255.5
    load_coefs(s);
    send_coord(12'd7, 12'd9, 0);
    settle_pipeline();
    s.c0 = -48'sd1;                               // just below zero
    load_coefs(s);
    send_coord('1, '0, 0);
    settle_pipeline();
    s.c0 = COEF_W'(1) <<< FRAC_BITS;              // negative term floors down
    s.x1 = -48'sd1;
    load_coefs(s);
    send_coord(12'd0, 12'd0, 0);
    send_coord(12'd1, 12'd0, 0);
    send_coord('1, '1, 0);
    settle_pipeline();
  endtask

  // largest and smallest coefficients at the corners and bit patterns
  task automatic test_coef_extremes();
    coef_t s;
    s = {NUM_COEFS{COEF_MAX}};
    load_coefs(s);
    send_coord('0, '0, 0);
    send_coord('1, '1, 0);
    send_coord(12'hAAA, 12'h555, 0);
    settle_pipeline();
    s = {NUM_COEFS{COEF_MIN}};
    load_coefs(s);
    send_coord('0, '0, 0);
    send_coord('1, '1, 0);
    send_coord(12'h555, 12'hAAA, 0);
    settle_pipeline();
    // opposite signs on the two axes nearly cancel on the diagonal
    s = '0;
    s.c0 = COEF_W'(128) <<< FRAC_BITS;
    s.y1 = COEF_MAX;
    s.y2 = COEF_MAX;
    s.y3 = COEF_MAX;
    s.x1 = COEF_MIN;
    s.x2 = COEF_MIN;
    s.x3 = COEF_MIN;
    load_coefs(s);
    send_coord('1, '1, 0);
    send_coord(12'd1, 12'd1, 0);
    send_coord('1, '0, 0);
    send_coord('0, '1, 0);
    settle_pipeline();
  endtask

  // random coordinates over several surfaces, cycling the idle pattern
  task automatic test_random_surfaces();
    coef_t s;
    for (int set = 0; set < RAND_SETS; set++) begin
      s = (set % 4 == 3) ? rand_full_range() : rand_surface();
      load_coefs(s);
      tx_idle_on  = set[0];
      rx_idle_on <= set[1];
      for (int i = 0; i < SET_ITEMS; i++)
        send_coord(rand_coord(), rand_coord(), tx_gap());
      settle_pipeline();
    end
  endtask

  // hold the output off while coordinates keep coming, so the core fills up
  task automatic test_backpressure();
    load_coefs(rand_surface());
    tx_idle_on  = 1'b0;
    rx_idle_on <= 1'b0;
    hold_seq   <= hold_seq + 1;
    for (int i = 0; i < 3 * NUM_STAGES; i++)
      send_coord(rand_coord(), rand_coord(), 0);
    settle_pipeline();
  endtask

  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    col        <= '0;
    row        <= '0;
    cfg_wen    <= 1'b0;
    cfg_addr   <= '0;
    cfg_wdata  <= '0;
    rx_idle_on <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_clamp_edges();
    test_coef_extremes();
    test_random_surfaces();
    test_backpressure();

    // let any stray item show up before judging
    settle_pipeline();
    repeat (2 * NUM_STAGES) @(posedge clk);

    $display("Run covered %0d coordinates over %0d coefficient sets, %0d items checked.",
             coords_sent, coef_sets_loaded, lum_checked);
    $display("%0d items clamped; input held off for %0d cycles; %0d mismatches.",
             clamp_seen, in_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && lum_expected_q.size() == 0) begin
      $display("tb_cubic_shading_surface_eval_core passed");
    end else begin
      $display("tb_cubic_shading_surface_eval_core failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d items still expected.", lum_expected_q.size());
    $display("tb_cubic_shading_surface_eval_core failed");
    $finish;
  end

endmodule

// ===== cubic_shading_surface_eval_core.f =====
hdl/csse_pkg.sv
hdl/csse_coef_regs.sv
hdl/csse_pow.sv
hdl/csse_term.sv
hdl/csse_sum.sv
hdl/cubic_shading_surface_eval_core.sv
sim/tb_cubic_shading_surface_eval_core.sv
